@@ rtl/hfr_pkg.sv @@
`timescale 1ns / 1ps

package hfr_pkg;

  localparam int unsigned ADDR_W = 28;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned LEN_W  = 11;

  localparam logic [7:0]        FLAG_BYTE      = 8'h7E;
  localparam logic [15:0]       CRC_INIT       = 16'hFFFF;
  localparam logic [15:0]       CRC_POLY       = 16'h8408;
  localparam logic [3:0]        FMT_TYPE       = 4'hA;
  localparam logic [7:0]        LLC_DSAP       = 8'hE6;
  localparam logic [7:0]        LLC_SSAP       = 8'hE7;
  localparam logic [7:0]        LLC_QUAL       = 8'h00;
  localparam logic [CNT_W-1:0]  MAX_PAYLOAD    = 13'd4096;
  localparam logic [LEN_W-1:0]  BYTES_MAX      = 11'd2047;
  localparam logic [2:0]        ADDR_BYTES_MAX = 3'd4;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_ACCEPT  = 2'd2,
    EV_REJECT  = 2'd3
  } hfr_event_e;

  typedef struct packed {
    hfr_event_e        event_kind;
    logic [7:0]        payload_byte;
    logic [ADDR_W-1:0] dest_address;
    logic [ADDR_W-1:0] src_address;
    logic [7:0]        control_byte;
    logic              segmented;
    logic [CNT_W-1:0]  payload_count;
  } hfr_result_t;

  // reflected CRC-16/X.25, one byte, LSB first
  function automatic logic [15:0] crc_x25_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/hfr_if.sv @@
`timescale 1ns / 1ps

interface hfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  payload_byte;
  logic [27:0] dest_address;
  logic [27:0] src_address;
  logic [7:0]  control_byte;
  logic        segmented;
  logic [12:0] payload_count;

  modport source (output valid, output event_kind, output payload_byte, output dest_address,
                  output src_address, output control_byte, output segmented,
                  output payload_count, input ready);
  modport sink (input valid, input event_kind, input payload_byte, input dest_address,
                input src_address, input control_byte, input segmented,
                input payload_count, output ready);
endinterface

@@ rtl/hfr_parse.sv @@
`timescale 1ns / 1ps

module hfr_parse
  import hfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [7:0]  rx_byte_i,
  output hfr_result_t res_o
);

  typedef enum logic [7:0] {
    PH_HUNT   = 8'b0000_0001,
    PH_FMT_HI = 8'b0000_0010,
    PH_FMT_LO = 8'b0000_0100,
    PH_DEST   = 8'b0000_1000,
    PH_SRC    = 8'b0001_0000,
    PH_CTRL   = 8'b0010_0000,
    PH_HCS    = 8'b0100_0000,
    PH_INFO   = 8'b1000_0000
  } hfr_phase_e;

  hfr_phase_e        phase_q, phase_d;
  logic [15:0]       crc_q, crc_d;
  logic [LEN_W-1:0]  frame_len_q, frame_len_d;
  logic [LEN_W-1:0]  bytes_seen_q, bytes_seen_d;
  logic              seg_q, seg_d;
  logic [ADDR_W-1:0] dest_q, dest_d;
  logic [2:0]        dest_len_q, dest_len_d;
  logic [ADDR_W-1:0] src_q, src_d;
  logic [2:0]        src_len_q, src_len_d;
  logic [7:0]        ctrl_q, ctrl_d;
  logic [15:0]       hcs_calc_q, hcs_calc_d;
  logic [15:0]       hcs_rx_q, hcs_rx_d;
  logic [15:0]       fcs_rx_q, fcs_rx_d;
  logic [1:0]        llc_q, llc_d;
  logic [CNT_W-1:0]  total_q, total_d;

  logic [LEN_W-1:0]  bs_inc;
  logic              rem_ge2;
  logic [15:0]       crc_step;
  logic              closing;
  logic              frame_ok;
  logic              llc_match;
  logic [LEN_W-1:0]  hdr_len;
  logic              do_clear;
  logic              show_old;
  hfr_event_e        kind;
  logic [7:0]        pbyte;

  always_comb begin
    bs_inc   = (bytes_seen_q < BYTES_MAX) ? bytes_seen_q + 11'd1 : bytes_seen_q;
    rem_ge2  = {1'b0, frame_len_q} >= ({1'b0, bs_inc} + 12'd2);
    crc_step = ((frame_len_q < 11'd2) || rem_ge2) ? crc_x25_byte(crc_q, rx_byte_i) : crc_q;
    closing  = (rx_byte_i == FLAG_BYTE) && (bytes_seen_q >= frame_len_q) &&
               (phase_q != PH_HUNT) && (phase_q != PH_FMT_HI) && (phase_q != PH_FMT_LO);
    frame_ok = (hcs_rx_q == hcs_calc_q) && ((crc_q ^ CRC_INIT) == fcs_rx_q) &&
               ((ctrl_q != 8'h00) || (total_q != '0));
    hdr_len  = 11'd5 + {8'h00, dest_len_q} + {8'h00, src_len_q};
    llc_match = !ctrl_q[0] && (total_q == '0) &&
                (((rx_byte_i == LLC_DSAP) && (llc_q == 2'd0)) ||
                 ((rx_byte_i == LLC_SSAP) && (llc_q == 2'd1)) ||
                 ((rx_byte_i == LLC_QUAL) && (llc_q == 2'd2)));

    phase_d      = phase_q;
    crc_d        = crc_q;
    frame_len_d  = frame_len_q;
    bytes_seen_d = bytes_seen_q;
    seg_d        = seg_q;
    dest_d       = dest_q;
    dest_len_d   = dest_len_q;
    src_d        = src_q;
    src_len_d    = src_len_q;
    ctrl_d       = ctrl_q;
    hcs_calc_d   = hcs_calc_q;
    hcs_rx_d     = hcs_rx_q;
    fcs_rx_d     = fcs_rx_q;
    llc_d        = llc_q;
    total_d      = total_q;
    do_clear     = 1'b0;
    show_old     = 1'b0;
    kind         = EV_NONE;
    pbyte        = 8'h00;

    if (phase_q == PH_HUNT) begin
      if (rx_byte_i == FLAG_BYTE) begin
        phase_d = PH_FMT_HI;
      end
    end else if (closing) begin
      // report the frame as it stands, then start hunting again
      kind     = frame_ok ? EV_ACCEPT : EV_REJECT;
      show_old = 1'b1;
      do_clear = 1'b1;
    end else begin
      bytes_seen_d = bs_inc;
      crc_d        = crc_step;
      unique case (phase_q)
        PH_FMT_HI: begin
          if (rx_byte_i == FLAG_BYTE) begin
            // repeated opening flag: skip it, restart the check
            bytes_seen_d = bytes_seen_q;
            crc_d        = CRC_INIT;
          end else if (rx_byte_i[7:4] != FMT_TYPE) begin
            do_clear = 1'b1;
          end else begin
            seg_d       = rx_byte_i[3];
            frame_len_d = {rx_byte_i[2:0], 8'h00};
            phase_d     = PH_FMT_LO;
          end
        end
        PH_FMT_LO: begin
          frame_len_d = {frame_len_q[10:8], rx_byte_i};
          phase_d     = PH_DEST;
        end
        PH_DEST: begin
          dest_len_d = dest_len_q + 3'd1;
          dest_d     = {dest_q[ADDR_W-8:0], rx_byte_i[7:1]};
          if (rx_byte_i[0]) begin
            phase_d = PH_SRC;
          end
          if (dest_len_d > ADDR_BYTES_MAX) begin
            do_clear = 1'b1;
          end
        end
        PH_SRC: begin
          src_len_d = src_len_q + 3'd1;
          src_d     = {src_q[ADDR_W-8:0], rx_byte_i[7:1]};
          if (rx_byte_i[0]) begin
            phase_d = PH_CTRL;
          end
          if (src_len_d > ADDR_BYTES_MAX) begin
            do_clear = 1'b1;
          end
        end
        PH_CTRL: begin
          ctrl_d     = rx_byte_i;
          hcs_calc_d = crc_step ^ CRC_INIT;
          phase_d    = PH_HCS;
        end
        PH_HCS: begin
          if (!rem_ge2) begin
            // no information field: the trailing bytes serve as FCS and HCS
            fcs_rx_d = {rx_byte_i, fcs_rx_q[15:8]};
            hcs_rx_d = fcs_rx_d;
          end else begin
            hcs_rx_d = {rx_byte_i, hcs_rx_q[15:8]};
            if (bs_inc == hdr_len) begin
              phase_d = PH_INFO;
            end
          end
        end
        PH_INFO: begin
          if (!rem_ge2) begin
            fcs_rx_d = {rx_byte_i, fcs_rx_q[15:8]};
          end else if (llc_match) begin
            llc_d = llc_q + 2'd1;
          end else if (total_q < MAX_PAYLOAD) begin
            total_d = total_q + 13'd1;
            kind    = EV_PAYLOAD;
            pbyte   = rx_byte_i;
          end
        end
        default: begin
        end
      endcase
    end

    if (do_clear) begin
      total_d      = seg_q ? total_q : '0;
      phase_d      = PH_HUNT;
      llc_d        = 2'd0;
      crc_d        = CRC_INIT;
      bytes_seen_d = '0;
      seg_d        = 1'b0;
      frame_len_d  = '0;
      dest_d       = '0;
      dest_len_d   = 3'd0;
      src_d        = '0;
      src_len_d    = 3'd0;
      ctrl_d       = 8'h00;
      hcs_rx_d     = 16'h0000;
      fcs_rx_d     = 16'h0000;
    end

    res_o.event_kind    = kind;
    res_o.payload_byte  = pbyte;
    res_o.dest_address  = show_old ? dest_q  : dest_d;
    res_o.src_address   = show_old ? src_q   : src_d;
    res_o.control_byte  = show_old ? ctrl_q  : ctrl_d;
    res_o.segmented     = show_old ? seg_q   : seg_d;
    res_o.payload_count = show_old ? total_q : total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      crc_q        <= CRC_INIT;
      frame_len_q  <= '0;
      bytes_seen_q <= '0;
      seg_q        <= 1'b0;
      dest_q       <= '0;
      dest_len_q   <= 3'd0;
      src_q        <= '0;
      src_len_q    <= 3'd0;
      ctrl_q       <= 8'h00;
      hcs_calc_q   <= 16'h0000;
      hcs_rx_q     <= 16'h0000;
      fcs_rx_q     <= 16'h0000;
      llc_q        <= 2'd0;
      total_q      <= '0;
    end else if (load_i) begin
      phase_q      <= phase_d;
      crc_q        <= crc_d;
      frame_len_q  <= frame_len_d;
      bytes_seen_q <= bytes_seen_d;
      seg_q        <= seg_d;
      dest_q       <= dest_d;
      dest_len_q   <= dest_len_d;
      src_q        <= src_d;
      src_len_q    <= src_len_d;
      ctrl_q       <= ctrl_d;
      hcs_calc_q   <= hcs_calc_d;
      hcs_rx_q     <= hcs_rx_d;
      fcs_rx_q     <= fcs_rx_d;
      llc_q        <= llc_d;
      total_q      <= total_d;
    end
  end

endmodule

@@ rtl/hfr_out.sv @@
`timescale 1ns / 1ps

module hfr_out
  import hfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  hfr_result_t res_i,
  input  logic        ready_i,
  output logic        valid_o,
  output logic        can_take_o,
  output hfr_result_t res_o
);

  logic        valid_q, valid_d;
  hfr_result_t res_q;

  // take a new item whenever the held result is gone or leaves this cycle
  assign can_take_o = !valid_q || ready_i;
  assign valid_d    = load_i || (valid_q && !ready_i);
  assign valid_o    = valid_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ rtl/hdlc_frame_receiver.sv @@
`timescale 1ns / 1ps

// HDLC type-3 frame receiver with CRC-16/X.25 header and frame checks.
// Input channel in_i carries one line byte per item (flags included, no
// byte stuffing). Output channel out_o carries exactly one result per input
// item: an event code (none, payload byte, frame accepted, frame rejected),
// the payload byte, and the addresses, control byte, segmentation bit and
// payload count of the frame in progress.
// Latency: the result for an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle; the parser state updates in the same cycle
// an item is accepted, and a single output register holds the result.
// When out_o stalls, the held result stays put and in_i.ready drops until it
// is taken; in_i.ready is high whenever the output register is empty or is
// being emptied in that cycle.
// Reset (rst_ni low, asynchronous) puts the parser into flag hunting with
// all frame state cleared and empties the output register.
module hdlc_frame_receiver
  import hfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  hfr_in_if.sink     in_i,
  hfr_out_if.source  out_o
);

  logic        fire;
  logic        can_take;
  hfr_result_t res_next;
  hfr_result_t res_held;

  assign in_i.ready = can_take;
  assign fire       = in_i.valid && can_take;

  hfr_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (fire),
    .rx_byte_i (in_i.rx_byte),
    .res_o     (res_next)
  );

  hfr_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .res_i      (res_next),
    .ready_i    (out_o.ready),
    .valid_o    (out_o.valid),
    .can_take_o (can_take),
    .res_o      (res_held)
  );

  assign out_o.event_kind    = res_held.event_kind;
  assign out_o.payload_byte  = res_held.payload_byte;
  assign out_o.dest_address  = res_held.dest_address;
  assign out_o.src_address   = res_held.src_address;
  assign out_o.control_byte  = res_held.control_byte;
  assign out_o.segmented     = res_held.segmented;
  assign out_o.payload_count = res_held.payload_count;

endmodule

@@ rtl/hfr_checker.sv @@
`timescale 1ns / 1ps

module hfr_checker
  import hfr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  event_kind_i,
  input logic [7:0]  payload_byte_i,
  input logic [12:0] payload_count_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_kind_i) &&
    $stable(payload_byte_i))
    else $error("stalled result changed");

  // every accepted item yields a result in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted item produced no result");

  // a stalled result blocks the input side
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input accepted while result stalled");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i != EV_PAYLOAD) |-> payload_byte_i == 8'h00)
    else $error("payload byte set without payload event");

  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == EV_PAYLOAD) |-> payload_count_i != 13'd0)
    else $error("payload event with zero count");

endmodule

bind hdlc_frame_receiver hfr_checker u_hfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .event_kind_i    (out_o.event_kind),
  .payload_byte_i  (out_o.payload_byte),
  .payload_count_i (out_o.payload_count)
);
